[rtl/core/bprq_pkg.sv]
// bprq_pkg: shared types and codes for the bitmap priority run queue.
// Used by the controller, datapath and top level; depends on nothing.
package bprq_pkg;
    localparam logic [1:0] KIND_ENQ    = 2'd0;
    localparam logic [1:0] KIND_REMOVE = 2'd1;
    localparam logic [1:0] KIND_PICK   = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NONE      = 2'd1;
    localparam logic [1:0] ST_QUEUED    = 2'd2;
    localparam logic [1:0] ST_NOT_QUEUED = 2'd3;

    // controller -> datapath
    typedef struct packed {
        logic load;   // capture transaction, issue thread reads
        logic decide; // evaluate, issue head/tail reads
        logic commit; // write back links and masks, produce result
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic done;
    } t_sts;
endpackage

[rtl/core/bprq_ram.sv]
// bprq_ram: generic single-write, single-read RAM with registered read.
// No dependencies.
module bprq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

[rtl/core/bprq_ctrl.sv]
// bprq_ctrl: sequencing state machine of the run queue.
// Depends on bprq_pkg.
module bprq_ctrl import bprq_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  logic i_out_free,
    output logic o_stall,
    output t_cmd o_cmd
);
    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_READ   = 5'b00010,
        S_DECIDE = 5'b00100,
        S_LINK   = 5'b01000,
        S_COMMIT = 5'b10000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (i_valid) n_state = S_READ;
            S_READ:   n_state = S_DECIDE;
            S_DECIDE: n_state = S_LINK;
            S_LINK:   n_state = S_COMMIT;
            S_COMMIT: if (i_out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_stall      = (r_state != S_IDLE);
    assign o_cmd.load   = (r_state == S_IDLE) && i_valid;
    assign o_cmd.decide = (r_state == S_READ);
    assign o_cmd.commit = (r_state == S_COMMIT) && i_out_free;
endmodule

[rtl/core/bprq_dp.sv]
// bprq_dp: datapath with masks, totals, bucket and link memories.
// Depends on bprq_pkg and bprq_ram.
module bprq_dp import bprq_pkg::*; #(
    parameter int NUM_PRIOS   = 16,
    parameter int NUM_GROUPS  = 16,
    parameter int MAX_THREADS = 256
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cmd       i_cmd,
    input  logic [1:0] i_kind,
    input  logic [7:0] i_thread_id,
    input  logic [3:0] i_priority_req,
    input  logic [3:0] i_group,
    input  logic       i_to_expired,
    output logic [1:0] o_status,
    output logic [7:0] o_picked_thread,
    output logic [3:0] o_picked_priority,
    output logic [3:0] o_picked_group,
    output logic       o_sets_swapped,
    output logic [8:0] o_active_total,
    output logic [8:0] o_expired_total
);
    localparam int PW = (NUM_PRIOS > 1) ? $clog2(NUM_PRIOS) : 1;
    localparam int GW = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
    localparam int TW = $clog2(MAX_THREADS);
    localparam int BW = 1 + PW + GW;
    localparam int BD = 2 * (1 << PW) * (1 << GW);
    localparam int IW = 1 + PW + GW;

    // control state
    logic                  r_asel;
    logic [NUM_PRIOS-1:0]  r_pmask [2];
    logic [NUM_GROUPS-1:0] r_gmask [2][NUM_PRIOS];
    logic [8:0]            r_total [2];
    logic [MAX_THREADS-1:0] r_queued;

    // captured transaction
    logic [1:0]  r_kind;
    logic [7:0]  r_tid;
    logic        r_tid_ok;
    logic [PW-1:0] r_p;
    logic [GW-1:0] r_g;
    logic        r_texp;

    // decision registers
    logic [TW-1:0] r_t;       // thread being unlinked / appended
    logic          r_s;
    logic [PW-1:0] r_bp;
    logic [GW-1:0] r_bg;
    logic          r_swap;
    logic [1:0]    r_st;
    logic          r_do_app, r_do_unl, r_nonempty;

    // RAMs
    logic          head_we, tail_we, next_we, prev_we, info_we;
    logic [BW-1:0] head_wa, tail_wa, head_ra, tail_ra;
    logic [TW-1:0] head_wd, tail_wd, head_rd, tail_rd;
    logic [TW-1:0] next_wa, prev_wa, next_ra, prev_ra, info_wa, info_ra;
    logic [TW-1:0] next_wd, prev_wd, next_rd, prev_rd;
    logic [IW-1:0] info_wd, info_rd;

    bprq_ram #(.WIDTH(TW), .DEPTH(BD)) u_head (.i_clk, .i_we(head_we),
        .i_waddr(head_wa), .i_wdata(head_wd), .i_raddr(head_ra), .o_rdata(head_rd));
    bprq_ram #(.WIDTH(TW), .DEPTH(BD)) u_tail (.i_clk, .i_we(tail_we),
        .i_waddr(tail_wa), .i_wdata(tail_wd), .i_raddr(tail_ra), .o_rdata(tail_rd));
    bprq_ram #(.WIDTH(TW), .DEPTH(MAX_THREADS)) u_next (.i_clk, .i_we(next_we),
        .i_waddr(next_wa), .i_wdata(next_wd), .i_raddr(next_ra), .o_rdata(next_rd));
    bprq_ram #(.WIDTH(TW), .DEPTH(MAX_THREADS)) u_prev (.i_clk, .i_we(prev_we),
        .i_waddr(prev_wa), .i_wdata(prev_wd), .i_raddr(prev_ra), .o_rdata(prev_rd));
    bprq_ram #(.WIDTH(IW), .DEPTH(MAX_THREADS)) u_info (.i_clk, .i_we(info_we),
        .i_waddr(info_wa), .i_wdata(info_wd), .i_raddr(info_ra), .o_rdata(info_rd));

    // input conditioning
    logic [PW-1:0] in_p;
    logic [GW-1:0] in_g;
    always_comb begin
        in_p = (32'(i_priority_req) >= NUM_PRIOS) ? PW'(NUM_PRIOS - 1)
                                                  : PW'(i_priority_req);
        in_g = (32'(i_group) >= NUM_GROUPS) ? GW'(NUM_GROUPS - 1) : GW'(i_group);
    end

    // decide-stage evaluation from captured transaction and thread info
    logic          d_queued, d_swap, d_s;
    logic [PW-1:0] d_bp;
    logic [GW-1:0] d_bg;
    logic [NUM_PRIOS-1:0] d_pm;
    logic [NUM_GROUPS-1:0] d_gm;
    logic [TW-1:0] tid_t;
    always_comb begin
        tid_t    = TW'(r_tid);
        d_queued = r_tid_ok && r_queued[tid_t];
        d_swap   = (r_kind == KIND_PICK) && (r_pmask[r_asel] == '0);
        d_s      = r_asel ^ d_swap;
        d_pm     = r_pmask[d_s];
        d_bp     = '0;
        for (int i = NUM_PRIOS - 1; i >= 0; i--) begin
            if (d_pm[i]) d_bp = PW'(i);
        end
        d_gm = r_gmask[d_s][d_bp];
        d_bg = '0;
        for (int i = NUM_GROUPS - 1; i >= 0; i--) begin
            if (d_gm[i]) d_bg = GW'(i);
        end
    end

    // read address selection: load stage reads info; decide reads buckets,
    // later stages keep reading the bucket latched at decide
    logic [BW-1:0] dec_b;
    always_comb begin
        if (r_kind == KIND_PICK) dec_b = {d_s, d_bp, d_bg};
        else if (r_kind == KIND_REMOVE) dec_b = info_rd;
        else dec_b = {r_asel ^ r_texp, r_p, r_g};
        head_ra = i_cmd.decide ? dec_b : {r_s, r_bp, r_bg};
        tail_ra = i_cmd.decide ? dec_b : {r_s, r_bp, r_bg};
        info_ra = TW'(i_thread_id);
        next_ra = r_t;
        prev_ra = r_t;
    end

    // pick path's thread is only known after the head read, so for a pick the
    // link reads are issued only once that thread is latched after decide (the
    // controller's link state leaves room for them before commit)
    logic r_lnk;

    // commit-stage link update
    logic          is_head, is_tail;
    logic [TW-1:0] ut, nx, pv;
    logic [BW-1:0] cb;
    always_comb begin
        ut      = r_t;
        cb      = {r_s, r_bp, r_bg};
        nx      = next_rd;
        pv      = prev_rd;
        is_head = head_rd == ut;
        is_tail = tail_rd == ut;
        head_we = 1'b0; tail_we = 1'b0; next_we = 1'b0; prev_we = 1'b0; info_we = 1'b0;
        head_wa = cb; tail_wa = cb; head_wd = ut; tail_wd = ut;
        next_wa = ut; next_wd = ut; prev_wa = ut; prev_wd = ut;
        info_wa = ut; info_wd = {r_s, r_bp, r_bg};
        if (i_cmd.commit && r_lnk) begin
            if (r_do_app) begin
                info_we = 1'b1;
                tail_we = 1'b1;
                if (r_nonempty) begin
                    // link old tail forward; prev of new = old tail
                    next_we = 1'b1; next_wa = tail_rd; next_wd = ut;
                    prev_we = 1'b1; prev_wd = tail_rd;
                end else begin
                    head_we = 1'b1;
                    prev_we = 1'b1;
                end
            end else if (r_do_unl) begin
                if (is_head && is_tail) begin
                    // bucket empties; masks handled below
                end else if (is_head) begin
                    head_we = 1'b1; head_wd = nx;
                    prev_we = 1'b1; prev_wa = nx; prev_wd = nx;
                end else if (is_tail) begin
                    tail_we = 1'b1; tail_wd = pv;
                    next_we = 1'b1; next_wa = pv; next_wd = pv;
                end else begin
                    next_we = 1'b1; next_wa = pv; next_wd = nx;
                    prev_we = 1'b1; prev_wa = nx; prev_wd = pv;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_asel   <= 1'b0;
            r_pmask  <= '{default: '0};
            r_gmask  <= '{default: '{default: '0}};
            r_total  <= '{default: '0};
            r_queued <= '0;
            r_lnk    <= 1'b0;
            r_do_app <= 1'b0;
            r_do_unl <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_kind   <= i_kind;
                r_tid    <= i_thread_id;
                r_tid_ok <= 32'(i_thread_id) < MAX_THREADS;
                r_p      <= in_p;
                r_g      <= in_g;
                r_texp   <= i_to_expired;
                r_lnk    <= 1'b0;
                r_do_app <= 1'b0;
                r_do_unl <= 1'b0;
            end
            if (i_cmd.decide) begin
                r_swap     <= d_swap;
                r_asel     <= d_s;
                r_t        <= tid_t;
                case (r_kind)
                    KIND_ENQ: begin
                        if (!r_tid_ok) begin
                            r_st <= ST_NOT_QUEUED;
                        end else if (d_queued) begin
                            r_st <= ST_QUEUED;
                        end else begin
                            r_st     <= ST_OK;
                            r_do_app <= 1'b1;
                        end
                        r_s  <= r_asel ^ r_texp;
                        r_bp <= r_p;
                        r_bg <= r_g;
                        r_nonempty <= r_gmask[r_asel ^ r_texp][r_p][r_g];
                        r_lnk <= 1'b1;
                    end
                    KIND_REMOVE: begin
                        if (!d_queued) begin
                            r_st <= ST_NOT_QUEUED;
                        end else begin
                            r_st     <= ST_OK;
                            r_do_unl <= 1'b1;
                        end
                        {r_s, r_bp, r_bg} <= info_rd;
                        r_lnk <= 1'b1;
                    end
                    KIND_PICK: begin
                        if (d_pm == '0) begin
                            r_st <= ST_NONE;
                        end else begin
                            r_st     <= ST_OK;
                            r_do_unl <= 1'b1;
                        end
                        r_s  <= d_s;
                        r_bp <= d_bp;
                        r_bg <= d_bg;
                        r_lnk <= 1'b0; // thread comes from head read
                    end
                    default: begin
                        r_st  <= ST_OK;
                        r_lnk <= 1'b1;
                    end
                endcase
            end else if (!r_lnk && !i_cmd.load && r_kind == KIND_PICK) begin
                // head read is back: fetch that thread's links next cycle
                r_t   <= (32'(head_rd) >= MAX_THREADS) ? '0 : head_rd;
                r_lnk <= 1'b1;
            end
            if (i_cmd.commit && r_lnk) begin
                if (r_do_app) begin
                    r_gmask[r_s][r_bp][r_bg] <= 1'b1;
                    r_pmask[r_s][r_bp]       <= 1'b1;
                    r_total[r_s]             <= r_total[r_s] + 9'd1;
                    r_queued[ut]             <= 1'b1;
                end else if (r_do_unl) begin
                    if (is_head && is_tail) begin
                        r_gmask[r_s][r_bp][r_bg] <= 1'b0;
                        if ((r_gmask[r_s][r_bp] & ~(NUM_GROUPS'(1) << r_bg)) == '0) begin
                            r_pmask[r_s][r_bp] <= 1'b0;
                        end
                    end
                    r_total[r_s] <= r_total[r_s] - 9'd1;
                    r_queued[ut] <= 1'b0;
                end
            end
        end
    end

    // result registers
    logic [8:0] tot_a, tot_e;
    always_comb begin
        tot_a = r_total[r_asel];
        tot_e = r_total[~r_asel];
    end
    assign o_status          = r_st;
    assign o_picked_thread   = r_do_unl ? 8'(r_t) : 8'd0;
    assign o_picked_priority = r_do_unl ? 4'(r_bp) : 4'd0;
    assign o_picked_group    = r_do_unl ? 4'(r_bg) : 4'd0;
    assign o_sets_swapped    = r_swap;
    assign o_active_total    = tot_a;
    assign o_expired_total   = tot_e;
endmodule

[rtl/core/bitmap_priority_run_queue.sv]
// Top level of the bitmap priority run queue: sequencer plus datapath.
// Depends on bprq_pkg, bprq_ctrl, bprq_dp, bprq_ram.
//
// Run queue with two sets (active and expired), each holding a FIFO per
// priority and group pair, kept as linked lists in registered-read RAMs with
// per-set priority and group bitmaps in flip-flops. One transaction
// (enqueue, remove or pick) is processed at a time and yields one result.
// A transaction runs from acceptance to result through these steps: read thread
// info, decide and read the bucket head/tail, read the neighbor links (a
// pick learns its thread only from the head read), commit, then register
// the result. The next transaction can be accepted at the edge the result
// appears. If the previous result is still held under stall when a
// transaction reaches commit, commit waits until that result is taken. The
// result is held in an output register until taken. No clearing pass is
// needed after reset.
module bitmap_priority_run_queue import bprq_pkg::*; #(
    parameter int NUM_PRIOS   = 16,
    parameter int NUM_GROUPS  = 16,
    parameter int MAX_THREADS = 256
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [1:0] i_kind,
    input  logic [7:0] i_thread_id,
    input  logic [3:0] i_priority_req,
    input  logic [3:0] i_group,
    input  logic       i_to_expired,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [1:0] o_status,
    output logic [7:0] o_picked_thread,
    output logic [3:0] o_picked_priority,
    output logic [3:0] o_picked_group,
    output logic       o_sets_swapped,
    output logic [8:0] o_active_total,
    output logic [8:0] o_expired_total
);
    t_cmd cmd;
    logic out_free;
    logic [1:0] st;
    logic [7:0] pt;
    logic [3:0] pp, pg;
    logic sw;
    logic [8:0] ta, te;
    logic r_fin;

    // free when the output register is empty or draining this cycle
    assign out_free = !o_valid || !i_stall;

    bprq_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .i_out_free(out_free),
        .o_stall, .o_cmd(cmd)
    );

    bprq_dp #(.NUM_PRIOS(NUM_PRIOS), .NUM_GROUPS(NUM_GROUPS),
              .MAX_THREADS(MAX_THREADS)) u_dp (
        .i_clk, .i_rst_n, .i_cmd(cmd), .i_kind, .i_thread_id, .i_priority_req,
        .i_group, .i_to_expired, .o_status(st), .o_picked_thread(pt),
        .o_picked_priority(pp), .o_picked_group(pg), .o_sets_swapped(sw),
        .o_active_total(ta), .o_expired_total(te)
    );

    // capture the result the cycle after commit, when totals have settled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fin   <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            r_fin <= cmd.commit;
            if (r_fin) begin
                o_valid <= 1'b1;
            end else if (!i_stall) begin
                o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_fin) begin
            o_status          <= st;
            o_picked_thread   <= pt;
            o_picked_priority <= pp;
            o_picked_group    <= pg;
            o_sets_swapped    <= sw;
            o_active_total    <= ta;
            o_expired_total   <= te;
        end
    end
endmodule

[rtl/core/bprq_checker.sv]
// bprq_checker: port-level assertions for the run queue, bound to the top.
// Depends on bprq_pkg and bitmap_priority_run_queue.
module bprq_checker import bprq_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_stall,
    input logic       o_valid,
    input logic       i_stall,
    input logic [1:0] o_status,
    input logic [8:0] o_active_total,
    input logic [8:0] o_expired_total
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_status))
        else $error("result dropped under stall");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("accepted a second transaction while busy");
    a_tot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_active_total + o_expired_total) <= 10'd256)
        else $error("totals exceed thread count");
    a_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_NONE |-> o_active_total == 9'd0)
        else $error("nothing to pick with nonempty active set");
endmodule

bind bitmap_priority_run_queue bprq_checker u_chk (.*);

[test/tb_top.sv]
`timescale 1ns / 1ps
// tb_top: self-checking testbench for bitmap_priority_run_queue.
// Depends on bprq_pkg and the block; predicts each result with a run-queue model
// kept here and compares every returned transaction field by field.
module tb_top;
    import bprq_pkg::*;

    localparam int NPRIO    = 16;
    localparam int NGROUP   = 16;
    localparam int NTHREAD  = 256;
    localparam int N_RANDOM = 830;
    localparam int LIMIT    = 400000;
    localparam int PAUSE_AT = 300;

    // kind code with no operation behind it
    localparam logic [1:0] KIND_RESERVED = 2'd3;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] tid;
        logic [3:0] prio;
        logic [3:0] grp;
        logic       to_exp;
    } t_op;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] thread;
        logic [3:0] prio;
        logic [3:0] grp;
        logic       swapped;
        logic [8:0] act_total;
        logic [8:0] exp_total;
    } t_res;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_stall;
    logic [1:0] i_kind;
    logic [7:0] i_thread_id;
    logic [3:0] i_priority_req;
    logic [3:0] i_group;
    logic       i_to_expired;
    logic       o_valid;
    logic       i_stall;
    logic [1:0] o_status;
    logic [7:0] o_picked_thread;
    logic [3:0] o_picked_priority;
    logic [3:0] o_picked_group;
    logic       o_sets_swapped;
    logic [8:0] o_active_total;
    logic [8:0] o_expired_total;

    bitmap_priority_run_queue dut (.*);

    // Queue model: each bucket is an ordered list of thread ids.
    logic        act_sel;
    int unsigned bucket [2][NPRIO][NGROUP][$];
    int unsigned set_count [2];
    logic        queued [NTHREAD];
    logic        th_set [NTHREAD];
    logic [3:0]  th_prio [NTHREAD];
    logic [3:0]  th_grp [NTHREAD];

    t_op  op_queue [$];
    t_res expected_results [$];
    int   n_errors;
    int   cycle_count;
    logic send_done;
    logic drain_hold;
    logic paused;

    function automatic logic set_empty(input logic s);
        return set_count[s] == 0;
    endfunction

    // Drop a thread from its bucket.
    function automatic void unlink(input int unsigned t);
        int unsigned q [$];
        q = bucket[th_set[t]][th_prio[t]][th_grp[t]];
        foreach (q[i]) begin
            if (q[i] == t) begin
                q.delete(i);
                break;
            end
        end
        bucket[th_set[t]][th_prio[t]][th_grp[t]] = q;
        set_count[th_set[t]]--;
        queued[t] = 1'b0;
    endfunction

    function automatic t_res predict_run_queue(input t_op op);
        t_res r;
        logic s;
        logic found;
        r = '0;
        if (op.kind == KIND_ENQ) begin
            if (queued[op.tid]) begin
                r.status = ST_QUEUED;
            end else begin
                s = act_sel ^ op.to_exp;
                bucket[s][op.prio][op.grp].push_back(op.tid);
                set_count[s]++;
                queued[op.tid] = 1'b1;
                th_set[op.tid] = s;
                th_prio[op.tid] = op.prio;
                th_grp[op.tid] = op.grp;
            end
        end else if (op.kind == KIND_REMOVE) begin
            if (!queued[op.tid]) begin
                r.status = ST_NOT_QUEUED;
            end else begin
                r.thread = op.tid;
                r.prio = th_prio[op.tid];
                r.grp = th_grp[op.tid];
                unlink(op.tid);
            end
        end else if (op.kind == KIND_PICK) begin
            if (set_empty(act_sel)) begin
                act_sel = ~act_sel;
                r.swapped = 1'b1;
            end
            if (set_empty(act_sel)) begin
                r.status = ST_NONE;
            end else begin
                found = 1'b0;
                for (int p = 0; p < NPRIO && !found; p++) begin
                    for (int g = 0; g < NGROUP && !found; g++) begin
                        if (bucket[act_sel][p][g].size() != 0) begin
                            found = 1'b1;
                            r.thread = 8'(bucket[act_sel][p][g][0]);
                            r.prio = 4'(p);
                            r.grp = 4'(g);
                        end
                    end
                end
                unlink(r.thread);
            end
        end
        r.act_total = 9'(set_count[act_sel]);
        r.exp_total = 9'(set_count[~act_sel]);
        return r;
    endfunction

    function automatic t_op make_op(input logic [1:0] k, input int unsigned t,
                                    input int unsigned p, input int unsigned g,
                                    input logic e);
        t_op op;
        op.kind = k;
        op.tid = 8'(t);
        op.prio = 4'(p);
        op.grp = 4'(g);
        op.to_exp = e;
        return op;
    endfunction

    // Short gaps mostly, an occasional long one, and runs of none.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Fill the pending queue: directed cases first, then random traffic.
    initial begin
        int unsigned pool;
        int unsigned r;
        // Picks on an empty queue swap the sets back and forth.
        op_queue.push_back(make_op(KIND_PICK, 8'hff, 0, 0, 0));
        op_queue.push_back(make_op(KIND_PICK, 0, 15, 15, 1));
        op_queue.push_back(make_op(KIND_REMOVE, 8'h00, 0, 0, 0));
        op_queue.push_back(make_op(KIND_ENQ, 8'h00, 15, 15, 0));
        op_queue.push_back(make_op(KIND_ENQ, 8'hff, 0, 0, 1));
        op_queue.push_back(make_op(KIND_ENQ, 8'h55, 0, 0, 1));
        op_queue.push_back(make_op(KIND_ENQ, 8'haa, 15, 15, 0));
        op_queue.push_back(make_op(KIND_ENQ, 8'h0f, 15, 15, 0));
        op_queue.push_back(make_op(KIND_ENQ, 8'hf0, 15, 15, 0));
        op_queue.push_back(make_op(KIND_ENQ, 8'h00, 3, 3, 1)); // already queued
        op_queue.push_back(make_op(KIND_ENQ, 8'hff, 5, 5, 0)); // already queued
        op_queue.push_back(make_op(KIND_RESERVED, 8'h12, 7, 7, 1)); // unknown kind
        op_queue.push_back(make_op(KIND_REMOVE, 8'haa, 0, 0, 0)); // middle of list
        op_queue.push_back(make_op(KIND_REMOVE, 8'hf0, 0, 0, 0)); // tail
        op_queue.push_back(make_op(KIND_REMOVE, 8'haa, 0, 0, 0)); // not queued
        op_queue.push_back(make_op(KIND_PICK, 0, 0, 0, 0));
        op_queue.push_back(make_op(KIND_PICK, 0, 0, 0, 0));
        op_queue.push_back(make_op(KIND_PICK, 0, 0, 0, 0)); // swap to expired
        op_queue.push_back(make_op(KIND_PICK, 0, 0, 0, 0));
        op_queue.push_back(make_op(KIND_PICK, 0, 0, 0, 0));
        op_queue.push_back(make_op(KIND_REMOVE, 8'hff, 0, 0, 0));
        // Random: mostly small thread pools so that the lists stay busy.
        for (int i = 0; i < N_RANDOM; i++) begin
            pool = (i % 200 < 150) ? 24 : 255;
            r = $urandom_range(0, 99);
            op_queue.push_back(make_op(r < 48 ? KIND_ENQ : r < 70 ? KIND_REMOVE :
                                       r < 98 ? KIND_PICK : KIND_RESERVED,
                                       $urandom_range(0, pool),
                                       (i % 3 == 0) ? $urandom_range(0, 15)
                                                    : $urandom_range(0, 3),
                                       (i % 3 == 0) ? $urandom_range(0, 15)
                                                    : $urandom_range(0, 3),
                                       $urandom_range(0, 1)));
        end
    end

    // Driver: hold each transaction until accepted, then advance.
    int   send_gap;
    int   sent;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            send_gap <= 0;
            sent <= 0;
            send_done <= 1'b0;
            drain_hold <= 1'b0;
            paused <= 1'b0;
        end else if (i_valid && o_stall) begin
            // hold the stalled payload
        end else begin
            if (i_valid) begin
                expected_results.push_back(predict_run_queue(
                    make_op(i_kind, i_thread_id, i_priority_req, i_group, i_to_expired)));
                sent <= sent + 1;
            end
            if (drain_hold) begin
                // Pause mid-run until every result has drained.
                i_valid <= 1'b0;
                if (expected_results.size() == 0) drain_hold <= 1'b0;
            end else if (send_gap != 0) begin
                i_valid <= 1'b0;
                send_gap <= send_gap - 1;
            end else if (!paused && sent >= PAUSE_AT) begin
                i_valid <= 1'b0;
                drain_hold <= 1'b1;
                paused <= 1'b1;
            end else if (op_queue.size() != 0) begin
                t_op op;
                op = op_queue.pop_front();
                i_valid <= 1'b1;
                i_kind <= op.kind;
                i_thread_id <= op.tid;
                i_priority_req <= op.prio;
                i_group <= op.grp;
                i_to_expired <= op.to_exp;
                send_gap <= gap_len();
            end else begin
                i_valid <= 1'b0;
                send_done <= 1'b1;
            end
        end
    end

    // Monitor: check each returned transaction, stall at random.
    int stall_left;
    always @(posedge i_clk) begin
        t_res got;
        t_res want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            stall_left <= 0;
        end else begin
            if (o_valid && !i_stall) begin
                got = {o_status, o_picked_thread, o_picked_priority, o_picked_group,
                       o_sets_swapped, o_active_total, o_expired_total};
                if (expected_results.size() == 0) begin
                    $display("%0t: result with none expected: %h", $realtime, got);
                    n_errors++;
                end else begin
                    want = expected_results.pop_front();
                    if (got.status !== want.status)
                        $display("%0t: status exp %0d got %0d", $realtime, want.status, got.status);
                    if (got.thread !== want.thread)
                        $display("%0t: thread exp %0d got %0d", $realtime, want.thread, got.thread);
                    if (got.prio !== want.prio)
                        $display("%0t: priority exp %0d got %0d", $realtime, want.prio, got.prio);
                    if (got.grp !== want.grp)
                        $display("%0t: group exp %0d got %0d", $realtime, want.grp, got.grp);
                    if (got.swapped !== want.swapped)
                        $display("%0t: swapped exp %0d got %0d", $realtime,
                                 want.swapped, got.swapped);
                    if (got.act_total !== want.act_total)
                        $display("%0t: active total exp %0d got %0d", $realtime,
                                 want.act_total, got.act_total);
                    if (got.exp_total !== want.exp_total)
                        $display("%0t: expired total exp %0d got %0d", $realtime,
                                 want.exp_total, got.exp_total);
                    if (got !== want) n_errors++;
                end
            end
            if (stall_left != 0) begin
                stall_left <= stall_left - 1;
            end else begin
                stall_left <= gap_len();
                i_stall <= !i_stall;
            end
        end
    end

    // Reset, then wait for the drain and the trailing quiet period.
    initial begin
        n_errors = 0;
        act_sel = 1'b0;
        set_count[0] = 0;
        set_count[1] = 0;
        for (int t = 0; t < NTHREAD; t++) queued[t] = 1'b0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_kind = KIND_ENQ;
        i_thread_id = '0;
        i_priority_req = '0;
        i_group = '0;
        i_to_expired = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        wait (send_done && !i_valid && expected_results.size() == 0);
        repeat (20) @(posedge i_clk);
        if (n_errors == 0 && expected_results.size() == 0) begin
            $display("bitmap_priority_run_queue: match");
        end else begin
            $display("bitmap_priority_run_queue: mismatch");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        cycle_count = 0;
        while (cycle_count < LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("bitmap_priority_run_queue: mismatch");
        $finish;
    end
endmodule
